// ----- design/tsdpq_pkg.sv -----
// ----------------------------------------------------------------------------
// tsdpq_pkg
// Shared types and constants for the tape sense debounce and press qualifier.
// ----------------------------------------------------------------------------
package tsdpq_pkg;

    localparam int TIME_BITS  = 16;
    localparam int CFG_W      = 16;
    localparam int ERR_W      = 16;
    localparam int CMP_W      = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [2:0] {
        REG_ENABLE         = 3'd0,
        REG_CHECK_INTERVAL = 3'd1,
        REG_DEBOUNCE_TIME  = 3'd2,
        REG_MIN_PRESS      = 3'd3,
        REG_MAX_PRESS      = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        LED_NONE   = 2'd0,
        LED_FAULT  = 2'd1,
        LED_LINKED = 2'd2
    } led_code_t;

    typedef struct packed {
        logic             enable;
        logic [CFG_W-1:0] check_interval;
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] min_press;
        logic [CFG_W-1:0] max_press;
    } cfg_t;

    typedef struct packed {
        logic             check_done;
        logic [ERR_W-1:0] error_count;
        led_code_t        led_code;
        logic             feed_flag;
        logic             bad_press;
        logic             feed_request;
        logic             tape_loaded;
    } result_t;

    // saturating millisecond timer step
    function automatic logic [TIME_BITS-1:0] time_inc(input logic [TIME_BITS-1:0] t);
        logic [TIME_BITS-1:0] r;
        begin
            r = (&t) ? t : t + TIME_BITS'(1);
            return r;
        end
    endfunction

endpackage

// ----- design/tsdpq_regs.sv -----
// ----------------------------------------------------------------------------
// tsdpq_regs
// APB configuration registers: enable, check interval, debounce time and
// press length limits.
// ----------------------------------------------------------------------------
module tsdpq_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tsdpq_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tsdpq_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tsdpq_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    output tsdpq_pkg::cfg_t                  cfg
);
    import tsdpq_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_ENABLE:         cfg_next.enable         = pwdata[0];
                REG_CHECK_INTERVAL: cfg_next.check_interval = pwdata[CFG_W-1:0];
                REG_DEBOUNCE_TIME:  cfg_next.debounce_time  = pwdata[CFG_W-1:0];
                REG_MIN_PRESS:      cfg_next.min_press      = pwdata[CFG_W-1:0];
                REG_MAX_PRESS:      cfg_next.max_press      = pwdata[CFG_W-1:0];
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable         <= 1'b1;
            cfg_reg.check_interval <= CFG_W'(10);
            cfg_reg.debounce_time  <= CFG_W'(50);
            cfg_reg.min_press      <= CFG_W'(50);
            cfg_reg.max_press      <= CFG_W'(2000);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_ENABLE:         prdata = APB_DATA_W'(cfg_reg.enable);
            REG_CHECK_INTERVAL: prdata = APB_DATA_W'(cfg_reg.check_interval);
            REG_DEBOUNCE_TIME:  prdata = APB_DATA_W'(cfg_reg.debounce_time);
            REG_MIN_PRESS:      prdata = APB_DATA_W'(cfg_reg.min_press);
            REG_MAX_PRESS:      prdata = APB_DATA_W'(cfg_reg.max_press);
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/tape_sense_debounce_and_press_qualifier.sv -----
// ----------------------------------------------------------------------------
// tape_sense_debounce_and_press_qualifier
// Debounces the tape sense pin and qualifies manual presses by length.
// ----------------------------------------------------------------------------
// Usage:
//   Send one item per millisecond tick on the s_* stream (pin_level,
//   clear_flag). Every item gives exactly one result item on the m_* stream:
//   debounced tape status, feed request, bad press, sticky feed flag, LED
//   code, saturating error count and a flag for ticks that checked the pin.
//   The item is held in an input register, evaluated in a single pass
//   against the timer state and registered into the result register,
//   which drives m_tvalid and m_tdata until the result is taken.
//   One item per cycle is sustained while m_tready stays high; the only
//   loop is the state update, made as the item leaves the input register.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more item; s_tready then drops until the
//   result is taken.
//   Reset restores the register defaults, clears all timers and counters and
//   leaves a resync pending, so the first enabled tick loads tape status
//   from the pin. Write the APB registers only while the stream is idle.
// ----------------------------------------------------------------------------
module tape_sense_debounce_and_press_qualifier
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tsdpq_pkg::IN_DATA_W-1:0]  s_tdata,   // [0] pin_level, [1] clear_flag
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] tape_loaded, [1] feed_request, [2] bad_press, [3] feed_flag,
    // [5:4] led_code, [21:6] error_count, [22] check_done
    output logic [tsdpq_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tsdpq_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tsdpq_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tsdpq_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);
    import tsdpq_pkg::*;

    cfg_t cfg;

    tsdpq_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input and output stages
    logic    in_valid_reg;
    logic    pin_reg;
    logic    clr_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t res;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // tick state
    logic [TIME_BITS-1:0] ms_check_reg,  ms_check_next;
    logic [TIME_BITS-1:0] ms_change_reg, ms_change_next;
    logic [TIME_BITS-1:0] press_ms_reg,  press_ms_next;
    logic                 press_active_reg, press_active_next;
    logic                 tape_state_reg,   tape_state_next;
    logic                 tape_last_reg,    tape_last_next;
    logic                 press_last_reg,   press_last_next;
    logic                 sticky_reg,       sticky_next;
    logic [ERR_W-1:0]     fault_reg,        fault_next;
    logic                 synced_reg,       synced_next;

    always_comb
    begin
        ms_check_next     = time_inc(ms_check_reg);
        ms_change_next    = time_inc(ms_change_reg);
        press_ms_next     = time_inc(press_ms_reg);
        press_active_next = press_active_reg;
        tape_state_next   = tape_state_reg;
        tape_last_next    = tape_last_reg;
        press_last_next   = press_last_reg;
        sticky_next       = clr_reg ? 1'b0 : sticky_reg;
        fault_next        = fault_reg;
        synced_next       = synced_reg;
        res               = '0;
        res.led_code      = LED_NONE;

        if (!cfg.enable)
        begin
            synced_next = 1'b0;
        end
        else
        begin
            // load tape status straight from the pin on the first enabled tick
            if (!synced_reg)
            begin
                tape_state_next = !pin_reg;
                tape_last_next  = pin_reg;
                ms_change_next  = '0;
                synced_next     = 1'b1;
            end
            if (CMP_W'(ms_check_next) >= CMP_W'(cfg.check_interval))
            begin
                ms_check_next  = '0;
                res.check_done = 1'b1;

                if (!pin_reg && press_last_reg)
                begin
                    press_active_next = 1'b1;
                    press_ms_next     = '0;
                end
                else if (pin_reg && !press_last_reg && press_active_reg)
                begin
                    if (CMP_W'(press_ms_next) >= CMP_W'(cfg.min_press) &&
                        CMP_W'(press_ms_next) <= CMP_W'(cfg.max_press))
                    begin
                        res.feed_request = 1'b1;
                        sticky_next      = 1'b1;
                        res.led_code     = LED_LINKED;
                    end
                    else
                    begin
                        res.bad_press = 1'b1;
                    end
                    press_active_next = 1'b0;
                end
                press_last_next = pin_reg;

                if (pin_reg != tape_last_next &&
                    CMP_W'(ms_change_next) >= CMP_W'(cfg.debounce_time))
                begin
                    ms_change_next = '0;
                    if (!pin_reg != tape_state_next)
                    begin
                        tape_state_next = !pin_reg;
                        if (pin_reg)
                        begin
                            res.led_code = LED_FAULT;
                            if (!(&fault_reg))
                            begin
                                fault_next = fault_reg + ERR_W'(1);
                            end
                        end
                        else
                        begin
                            res.led_code = LED_LINKED;
                        end
                    end
                end
                tape_last_next = pin_reg;
            end
        end

        res.tape_loaded = tape_state_next;
        res.feed_flag   = sticky_next;
        res.error_count = fault_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            ms_check_reg     <= '0;
            ms_change_reg    <= '0;
            press_ms_reg     <= '0;
            press_active_reg <= 1'b0;
            tape_state_reg   <= 1'b0;
            tape_last_reg    <= 1'b1;
            press_last_reg   <= 1'b1;
            sticky_reg       <= 1'b0;
            fault_reg        <= '0;
            synced_reg       <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                ms_check_reg     <= ms_check_next;
                ms_change_reg    <= ms_change_next;
                press_ms_reg     <= press_ms_next;
                press_active_reg <= press_active_next;
                tape_state_reg   <= tape_state_next;
                tape_last_reg    <= tape_last_next;
                press_last_reg   <= press_last_next;
                sticky_reg       <= sticky_next;
                fault_reg        <= fault_next;
                synced_reg       <= synced_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            pin_reg <= s_tdata[0];
            clr_reg <= s_tdata[1];
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_reg);

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_press_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_reg.feed_request && out_reg.bad_press))
        else $error("feed request and bad press in the same item");

    a_no_check_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_reg.check_done) |->
            (!out_reg.feed_request && !out_reg.bad_press && out_reg.led_code == LED_NONE))
        else $error("press or LED event on a tick without a pin check");

    a_fault_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> fault_reg >= $past(fault_reg))
        else $error("error count went down");

    a_fault_with_led: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && fault_next != fault_reg) |=> out_reg.led_code == LED_FAULT)
        else $error("error count moved without error LED code");

    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(out_reg)))
        else $error("stalled result lost or changed");

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stream-level bench for the tape sense debounce and press qualifier.
// Items go in at random pacing from a queue, one result per item is collected
// under random back-pressure, and each result is checked field by field
// against a cycle-free behavioural copy of the tick logic. Register settings
// change between phases over APB, from the reset values to both extremes.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import tsdpq_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_SHOWN   = 10;

    // {clear_flag, pin_level} per tick: valid press with LED override,
    // bounce inside debounce, short press, accepted change with no new status,
    // clear with feed in the same tick, long press, plain clear
    localparam logic [1:0] OPENING [20] = '{
        2'b00, 2'b00, 2'b00, 2'b01, 2'b10, 2'b01, 2'b01, 2'b01, 2'b00, 2'b00,
        2'b00, 2'b11, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b01, 2'b11
    };

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // [0] pin_level, [1] clear_flag
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [0] tape_loaded, [1] feed_request, [2] bad_press, [3] feed_flag,
    // [5:4] led_code, [21:6] error_count, [22] check_done
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tape_sense_debounce_and_press_qualifier u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor copy of registers and tick state
    cfg_t                 regs = '{enable: 1'b1, check_interval: 16'd10,
                                   debounce_time: 16'd50, min_press: 16'd50,
                                   max_press: 16'd2000};
    logic [TIME_BITS-1:0] since_check    = '0;
    logic [TIME_BITS-1:0] since_change   = '0;
    logic [TIME_BITS-1:0] press_len      = '0;
    logic                 pressing       = 1'b0;
    logic                 tape_now       = 1'b0;
    logic                 tape_pin_seen  = 1'b1;
    logic                 press_pin_seen = 1'b1;
    logic                 feed_sticky    = 1'b0;
    logic [ERR_W-1:0]     faults         = '0;
    logic                 resynced       = 1'b0;

    logic [1:0] ticks_pending [$];
    result_t    status_due [$];

    logic item_taken   = 1'b0;
    logic result_taken = 1'b0;
    int   tx_hold      = 0;
    int   tx_streak    = 0;
    int   rx_hold      = 0;
    int   rx_streak    = 0;
    int   quiet        = 0;
    int   misses       = 0;
    int   results_seen = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [TIME_BITS-1:0] sat_step(input logic [TIME_BITS-1:0] t);
        return (&t) ? t : t + TIME_BITS'(1);
    endfunction

    function automatic result_t tick_status(input logic pin, input logic clr);
        result_t r;
        logic    loaded;
        r = '0;
        if (clr)
            feed_sticky = 1'b0;
        since_check  = sat_step(since_check);
        since_change = sat_step(since_change);
        press_len    = sat_step(press_len);
        if (!regs.enable)
            resynced = 1'b0;
        else
        begin
            if (!resynced)
            begin
                tape_now      = ~pin;
                tape_pin_seen = pin;
                since_change  = '0;
                resynced      = 1'b1;
            end
            if (since_check >= regs.check_interval)
            begin
                since_check  = '0;
                r.check_done = 1'b1;
                if (!pin && press_pin_seen)
                begin
                    pressing  = 1'b1;
                    press_len = '0;
                end
                else if (pin && !press_pin_seen && pressing)
                begin
                    if (press_len >= regs.min_press && press_len <= regs.max_press)
                    begin
                        r.feed_request = 1'b1;
                        feed_sticky    = 1'b1;
                        r.led_code     = LED_LINKED;
                    end
                    else
                        r.bad_press = 1'b1;
                    pressing = 1'b0;
                end
                press_pin_seen = pin;
                if (pin != tape_pin_seen && since_change >= regs.debounce_time)
                begin
                    loaded       = ~pin;
                    since_change = '0;
                    if (loaded != tape_now)
                    begin
                        tape_now = loaded;
                        if (!loaded)
                        begin
                            r.led_code = LED_FAULT;
                            if (faults != '1)
                                faults = faults + ERR_W'(1);
                        end
                        else
                            r.led_code = LED_LINKED;
                    end
                end
                tape_pin_seen = pin;
            end
        end
        r.tape_loaded = tape_now;
        r.feed_flag   = feed_sticky;
        r.error_count = faults;
        return r;
    endfunction

    function automatic string show(input result_t r);
        return $sformatf("tape=%0b feed=%0b bad=%0b flag=%0b led=%0d errs=%0d chk=%0b",
                         r.tape_loaded, r.feed_request, r.bad_press, r.feed_flag,
                         r.led_code, r.error_count, r.check_done);
    endfunction

    function automatic int draw_wait(inout int streak);
        if (streak > 0)
        begin
            streak--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            streak = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    task automatic report_miss(input string msg);
        misses++;
        if (misses <= MAX_SHOWN)
            $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    // input driver: present the next pending item after its drawn gap
    always @(negedge clk)
    begin
        logic                 nxt_valid;
        logic [IN_DATA_W-1:0] nxt_data;
        nxt_valid = s_tvalid;
        nxt_data  = s_tdata;
        if (item_taken)
        begin
            nxt_valid = 1'b0;
            tx_hold   = draw_wait(tx_streak);
        end
        if (rst_n && !nxt_valid && ticks_pending.size() != 0)
        begin
            if (tx_hold > 0)
                tx_hold--;
            else
            begin
                nxt_valid = 1'b1;
                nxt_data  = IN_DATA_W'(ticks_pending.pop_front());
            end
        end
        s_tvalid <= nxt_valid;
        s_tdata  <= nxt_data;
    end

    // result receiver: stall a drawn number of cycles before each item
    always @(negedge clk)
    begin
        if (result_taken)
            rx_hold = draw_wait(rx_streak);
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // monitor: predict on each accepted item, check each accepted result
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        item_taken   <= rst_n && s_tvalid && s_tready;
        result_taken <= rst_n && m_tvalid && m_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                status_due.push_back(tick_status(s_tdata[0], s_tdata[1]));
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got = m_tdata[$bits(result_t)-1:0];
                if (status_due.size() == 0)
                    report_miss($sformatf("nothing pending, got %s", show(got)));
                else
                begin
                    want = status_due.pop_front();
                    if (got.tape_loaded !== want.tape_loaded ||
                        got.feed_request !== want.feed_request ||
                        got.bad_press !== want.bad_press ||
                        got.feed_flag !== want.feed_flag ||
                        got.led_code !== want.led_code ||
                        got.error_count !== want.error_count ||
                        got.check_done !== want.check_done)
                        report_miss($sformatf("expected %s got %s", show(want), show(got)));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic apb_write(input reg_idx_t idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_W'(val);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENABLE:         regs.enable         = val[0];
            REG_CHECK_INTERVAL: regs.check_interval = val;
            REG_DEBOUNCE_TIME:  regs.debounce_time  = val;
            REG_MIN_PRESS:      regs.min_press      = val;
            REG_MAX_PRESS:      regs.max_press      = val;
            default:            ;
        endcase
    endtask

    task automatic set_config(input logic en, input logic [CFG_W-1:0] ci,
                              input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] mn,
                              input logic [CFG_W-1:0] mx);
        apb_write(REG_ENABLE, CFG_W'(en));
        apb_write(REG_CHECK_INTERVAL, ci);
        apb_write(REG_DEBOUNCE_TIME, db);
        apb_write(REG_MIN_PRESS, mn);
        apb_write(REG_MAX_PRESS, mx);
    endtask

    // hold until every item is in and every result is out
    task automatic drain_all();
        @(posedge clk);
        while (ticks_pending.size() != 0 || s_tvalid || status_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic rare_clear();
        return ($urandom_range(0, 9) == 0);
    endfunction

    // pin held at alternating levels for random stretches sized to the
    // current press window, with short bursts of one to three random ticks
    // between them; the last stretch is cut so exactly n ticks go in
    task automatic push_runs(input int n);
        int   k;
        int   len;
        int   span;
        logic lvl;
        span = int'(regs.max_press) + 3 * int'(regs.check_interval);
        if (span > 600)
            span = 600;
        if (span < 4)
            span = 4;
        lvl = 1'b1;
        k   = 0;
        while (k < n)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                len = $urandom_range(1, 3);
                if (len > n - k)
                    len = n - k;
                for (int i = 0; i < len; i++)
                    ticks_pending.push_back({rare_clear(), 1'($urandom_range(0, 1))});
            end
            else
            begin
                lvl = ~lvl;
                len = $urandom_range(1, span);
                if (len > n - k)
                    len = n - k;
                for (int i = 0; i < len; i++)
                    ticks_pending.push_back({rare_clear(), lvl});
            end
            k += len;
        end
    endtask

    initial
    begin
        int mn;
        int mx;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // register values straight out of reset
        push_runs(120);
        drain_all();

        set_config(1'b1, 16'd1, 16'd2, 16'd2, 16'd4);
        foreach (OPENING[i])
            ticks_pending.push_back(OPENING[i]);
        push_runs(60);
        drain_all();

        set_config(1'b0, 16'd1, 16'd2, 16'd2, 16'd4);
        push_runs(30);
        drain_all();

        // re-enable forces a resync; pause the sender halfway
        set_config(1'b1, 16'd1, 16'd2, 16'd2, 16'd4);
        push_runs(70);
        drain_all();
        push_runs(70);
        drain_all();

        set_config(1'b1, 16'd3, 16'd10, 16'd6, 16'd30);
        push_runs(150);
        drain_all();

        set_config(1'b1, 16'd2, 16'd0, 16'd0, 16'd0);
        push_runs(120);
        drain_all();

        // minimum above maximum: every press is bad
        set_config(1'b1, 16'd1, 16'd5, 16'd20, 16'd3);
        push_runs(120);
        drain_all();

        set_config(1'b1, 16'd1, 16'd0, 16'd0, 16'hFFFF);
        push_runs(120);
        drain_all();

        set_config(1'b1, 16'd10, 16'd50, 16'd50, 16'd300);
        push_runs(200);
        drain_all();

        for (int p = 0; p < 3; p++)
        begin
            mn = $urandom_range(0, 20);
            mx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, mn) : mn + $urandom_range(0, 40);
            set_config(1'b1, CFG_W'($urandom_range(1, 4)), CFG_W'($urandom_range(0, 30)),
                       CFG_W'(mn), CFG_W'(mx));
            push_runs(80);
            drain_all();
        end

        set_config(1'b1, 16'd1, 16'd0, 16'd1, 16'd8);
        push_runs(100);
        drain_all();

        if (misses == 0 && status_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
